@@ hdl/sctc_pkg.sv @@
// Shared types and constants for the script-class text classifier.
// No dependencies; imported by sctc_decide and the top level.
`timescale 1ns / 1ps

package sctc_pkg;

	// default counter width
	localparam int COUNT_BITS_DEF = 16;

	// result class codes
	typedef enum logic [2:0] {
		LANG_OTHERS = 3'd0,
		LANG_ZH     = 3'd1,
		LANG_JP     = 3'd2,
		LANG_KR     = 3'd3,
		LANG_EN     = 3'd4
	} lang_t;

	// code unit ranges
	localparam logic [15:0] IDEO_LO   = 16'h4E00;
	localparam logic [15:0] IDEO_HI   = 16'h9FFF;
	localparam logic [15:0] KANA_LO   = 16'h3040;
	localparam logic [15:0] KANA_HI   = 16'h30FF;
	localparam logic [15:0] HANGUL_LO = 16'hAC00;
	localparam logic [15:0] HANGUL_HI = 16'hD7AF;
	localparam logic [15:0] ASCII_HI  = 16'h007F;

	localparam int FIELD_BITS = 16;

endpackage

@@ hdl/sctc_decide.sv @@
// Class decision from the four final counts: pair rules, then weighted scores
// (kana times four plus ideographs, the others doubled). Depends on sctc_pkg.
`timescale 1ns / 1ps

module sctc_decide
	import sctc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic [COUNT_BITS-1:0] ideo,
	input  logic [COUNT_BITS-1:0] kana,
	input  logic [COUNT_BITS-1:0] hangul,
	input  logic [COUNT_BITS-1:0] ascii,
	output lang_t                 language
);

	// 4*kana + ideo stays below 8 * 2^COUNT_BITS
	localparam int SW = COUNT_BITS + 3;

	logic          z_nz, j_nz, k_nz, e_nz;
	logic [SW-1:0] sz, sj, sk, se;
	logic          top_z, top_j, top_k, top_e;

	always_comb begin
		z_nz = |ideo;
		j_nz = |kana;
		k_nz = |hangul;
		e_nz = |ascii;

		sz = {2'b00, ideo, 1'b0};
		sj = {1'b0, kana, 2'b00} + {3'b000, ideo};
		sk = {2'b00, hangul, 1'b0};
		se = {2'b00, ascii, 1'b0};

		top_z = (sz > sj) && (sz > se) && (sz > sk);
		top_j = (sj > sz) && (sj > se) && (sj > sk);
		top_e = (se > sj) && (se > sk) && (se > sz);
		top_k = (sk > sz) && (sk > se) && (sk > sj);

		if (!z_nz && !j_nz && !k_nz && !e_nz) begin
			language = LANG_OTHERS;
		end else if (z_nz && j_nz) begin
			language = LANG_JP;
		end else if (z_nz && e_nz) begin
			language = LANG_ZH;
		end else if (k_nz && e_nz) begin
			language = LANG_KR;
		end else if (j_nz && e_nz) begin
			language = LANG_JP;
		end else if (top_z) begin
			language = LANG_ZH;
		end else if (top_j) begin
			language = LANG_JP;
		end else if (top_e) begin
			language = LANG_EN;
		end else if (top_k) begin
			language = LANG_KR;
		end else begin
			language = LANG_OTHERS;
		end
	end

endmodule

@@ hdl/script_class_text_classifier_unit.sv @@
// Top level of the script-class text classifier: input register, counters,
// final-count register and result register. Depends on sctc_pkg, sctc_decide.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata[15:0] code_unit, tuser no_char, tlast last
// m_axis    out  m_axis_tvalid/tready       tdata language, four totals (see port)
//
// One code unit is taken every cycle unless a unit marked last waits in stage 1;
// the throughput is set by the single counter update in stage 1. A result is
// presented once the request marked last has passed the input reg (at the
// accepting edge), then the final-count reg, then the result reg.
// arst_n clears all valid flags and the four counters.
// A stalled result holds only the final-count and result registers; units
// that are not last keep flowing into the counters meanwhile, until the next
// unit marked last reaches stage 1 and waits there.

module script_class_text_classifier_unit
	import sctc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
	input  logic        s_axis_tuser,   // [0] no_char
	input  logic        s_axis_tlast,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] language, [18:3] ideograph_total, [34:19] kana_total,
	// [50:35] hangul_total, [66:51] ascii_total, [71:67] zero
	output logic [71:0] m_axis_tdata
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

	// ---------------- stage 1: registered input ----------------
	logic [15:0] cu_s1;
	logic        no_char_s1;
	logic        last_s1;
	logic        valid_s1;

	// ---------------- stage 2: final counts of a string ----------------
	logic [COUNT_BITS-1:0] ideo_s2, kana_s2, hangul_s2, ascii_s2;
	logic                  valid_s2;

	// running counters
	logic [COUNT_BITS-1:0] ideo_q, kana_q, hangul_q, ascii_q;
	logic [COUNT_BITS-1:0] ideo_nx, kana_nx, hangul_nx, ascii_nx;

	logic out_free, s2_free, s1_adv;
	logic is_ideo, is_kana, is_hangul, is_ascii;

	// result register frees when empty or taken; stage 2 when it can move on
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign s2_free       = !valid_s2 || out_free;
	// a non-last unit never needs stage 2, so it always moves
	assign s1_adv        = valid_s1 && (!last_s1 || s2_free);
	assign s_axis_tready = !valid_s1 || s1_adv;

	// range sort; the ranges do not overlap
	always_comb begin
		is_ideo   = !no_char_s1 && (cu_s1 >= IDEO_LO) && (cu_s1 <= IDEO_HI);
		is_kana   = !no_char_s1 && (cu_s1 >= KANA_LO) && (cu_s1 <= KANA_HI);
		is_hangul = !no_char_s1 && (cu_s1 >= HANGUL_LO) && (cu_s1 <= HANGUL_HI);
		is_ascii  = !no_char_s1 && (cu_s1 <= ASCII_HI);

		ideo_nx   = (is_ideo && ideo_q != CNT_MAX) ? ideo_q + CNT_ONE : ideo_q;
		kana_nx   = (is_kana && kana_q != CNT_MAX) ? kana_q + CNT_ONE : kana_q;
		hangul_nx = (is_hangul && hangul_q != CNT_MAX) ? hangul_q + CNT_ONE : hangul_q;
		ascii_nx  = (is_ascii && ascii_q != CNT_MAX) ? ascii_q + CNT_ONE : ascii_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cu_s1      <= s_axis_tdata;
			no_char_s1 <= s_axis_tuser;
			last_s1    <= s_axis_tlast;
		end
	end

	// counters: bump (saturating) on each unit in their range, clear once a string closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ideo_q   <= '0;
			kana_q   <= '0;
			hangul_q <= '0;
			ascii_q  <= '0;
		end else if (s1_adv) begin
			if (last_s1) begin
				ideo_q   <= '0;
				kana_q   <= '0;
				hangul_q <= '0;
				ascii_q  <= '0;
			end else begin
				ideo_q   <= ideo_nx;
				kana_q   <= kana_nx;
				hangul_q <= hangul_nx;
				ascii_q  <= ascii_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			ideo_s2   <= ideo_nx;
			kana_s2   <= kana_nx;
			hangul_s2 <= hangul_nx;
			ascii_s2  <= ascii_nx;
		end
	end

	// ---------------- stage 3: class and clipped totals ----------------
	lang_t language;

	sctc_decide #(
		.COUNT_BITS(COUNT_BITS)
	) u_decide (
		.ideo     (ideo_s2),
		.kana     (kana_s2),
		.hangul   (hangul_s2),
		.ascii    (ascii_s2),
		.language (language)
	);

	// widen by a field so the clip works for any counter width
	logic [COUNT_BITS+FIELD_BITS-1:0] ideo_w, kana_w, hangul_w, ascii_w;
	logic [FIELD_BITS-1:0]            ideo_c, kana_c, hangul_c, ascii_c;

	always_comb begin
		ideo_w   = {{FIELD_BITS{1'b0}}, ideo_s2};
		kana_w   = {{FIELD_BITS{1'b0}}, kana_s2};
		hangul_w = {{FIELD_BITS{1'b0}}, hangul_s2};
		ascii_w  = {{FIELD_BITS{1'b0}}, ascii_s2};

		ideo_c   = (|ideo_w[COUNT_BITS+FIELD_BITS-1:FIELD_BITS]) ?
		           {FIELD_BITS{1'b1}} : ideo_w[FIELD_BITS-1:0];
		kana_c   = (|kana_w[COUNT_BITS+FIELD_BITS-1:FIELD_BITS]) ?
		           {FIELD_BITS{1'b1}} : kana_w[FIELD_BITS-1:0];
		hangul_c = (|hangul_w[COUNT_BITS+FIELD_BITS-1:FIELD_BITS]) ?
		           {FIELD_BITS{1'b1}} : hangul_w[FIELD_BITS-1:0];
		ascii_c  = (|ascii_w[COUNT_BITS+FIELD_BITS-1:FIELD_BITS]) ?
		           {FIELD_BITS{1'b1}} : ascii_w[FIELD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			m_axis_tdata <= {5'b00000, ascii_c, hangul_c, kana_c, ideo_c, language};
		end
	end

endmodule
